// ===== hw/rtl/multi_stack_shared_memory_core_macros.svh =====
// Assertion macros shared by the checker of the multi-stack core.
// Each macro expands to one labeled concurrent assertion on i_clk, gated by i_rst_n.
`ifndef MULTI_STACK_SHARED_MEMORY_CORE_MACROS_SVH
`define MULTI_STACK_SHARED_MEMORY_CORE_MACROS_SVH

// same-cycle implication
`define MSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("multi-stack core: same-cycle check failed");

// next-cycle implication
`define MSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("multi-stack core: next-cycle check failed");

`endif

// ===== hw/rtl/msm_pkg.sv =====
// Shared types and constants of the multi-stack core.
// No dependencies; every module of the core refers to it by scoped names.
package msm_pkg;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;
    localparam int TOTAL_SIZE_W  = 11;
    localparam int STACK_COUNT_W = 4;
    localparam int INDEX_W       = 3;
    localparam int VALUE_W       = 32;

    localparam logic [TOTAL_SIZE_W-1:0]  TOTAL_SIZE_RESET  = 11'd1024;
    localparam logic [STACK_COUNT_W-1:0] STACK_COUNT_RESET = 4'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT = 2'd1;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                       cmd;
        logic [INDEX_W-1:0]         stack_index;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  popped_value;
        t_status                    status;
    } t_out_item;

    typedef struct packed {
        t_cmd                cmd;
        logic                bad_index;
        logic [INDEX_W-1:0]  stack_index;
        logic [VALUE_W-1:0]  value;
    } t_q_entry;

    typedef struct packed {
        logic busy;
        logic clear;
    } t_rebuild_ctl;

endpackage

// ===== hw/rtl/msm_bounds.sv =====
// Configuration registers and region-bound sequencer of the multi-stack core.
// Uses msm_pkg; a serial restoring divider works out each region base and capacity.
module msm_bounds #(
    parameter int MEM_DEPTH  = 1024,
    parameter int MAX_STACKS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [msm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [msm_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic [$clog2(MAX_STACKS+1)-1:0]        o_used_count,
    output msm_pkg::t_rebuild_ctl                  o_ctl,
    output logic [$clog2(MEM_DEPTH+1)-1:0]         o_base [MAX_STACKS],
    output logic [$clog2(MEM_DEPTH+1)-1:0]         o_cap  [MAX_STACKS]
);

    localparam int SZW  = $clog2(MEM_DEPTH+1);
    localparam int NSW  = $clog2(MAX_STACKS+1);
    localparam int KW   = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int NUMW = SZW + NSW;
    localparam int CNTW = $clog2(NUMW);
    localparam int REMW = NSW + 1;
    localparam int TW   = (SZW > msm_pkg::TOTAL_SIZE_W) ? SZW : msm_pkg::TOTAL_SIZE_W;
    localparam int CW   = (NSW > msm_pkg::STACK_COUNT_W) ? NSW : msm_pkg::STACK_COUNT_W;

    typedef enum logic [2:0] {
        S_START,
        S_DIV,
        S_STORE,
        S_LAST,
        S_IDLE
    } t_state;

    t_state                             r_state;
    logic [msm_pkg::TOTAL_SIZE_W-1:0]   r_total_size;
    logic [msm_pkg::STACK_COUNT_W-1:0]  r_stack_count;
    logic [NSW-1:0]                     r_k;
    logic [NUMW-1:0]                    r_acc;
    logic [NUMW-1:0]                    r_num;
    logic [NUMW-1:0]                    r_quo;
    logic [REMW-1:0]                    r_rem;
    logic [CNTW-1:0]                    r_cnt;
    logic [SZW-1:0]                     r_prev;
    logic [SZW-1:0]                     r_base [MAX_STACKS];
    logic [SZW-1:0]                     r_cap  [MAX_STACKS];

    logic [SZW-1:0]  m;
    logic [NSW-1:0]  n;
    logic [REMW-1:0] rem_sh;
    logic            ge;
    logic [REMW-1:0] n_rem;
    logic [NUMW-1:0] n_acc;
    logic [SZW-1:0]  bound;

    function automatic logic [SZW-1:0] span(input logic [SZW-1:0] lo, input logic [SZW-1:0] hi);
        span = (hi > lo) ? (hi - lo - 1'b1) : '0;
    endfunction

    // clamp configuration to what was built
    assign m = (TW'(r_total_size) > TW'(MEM_DEPTH)) ? SZW'(MEM_DEPTH) : SZW'(r_total_size);
    assign n = (CW'(r_stack_count) > CW'(MAX_STACKS)) ? NSW'(MAX_STACKS) : NSW'(r_stack_count);

    // one quotient bit per cycle
    assign rem_sh = {r_rem[REMW-2:0], r_num[NUMW-1]};
    assign ge     = (rem_sh >= {1'b0, n});
    assign n_rem  = ge ? (rem_sh - {1'b0, n}) : rem_sh;
    assign n_acc  = r_acc + NUMW'(m);
    assign bound  = r_quo[SZW-1:0] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_START;
            r_total_size  <= msm_pkg::TOTAL_SIZE_RESET;
            r_stack_count <= msm_pkg::STACK_COUNT_RESET;
        end else begin
            unique case (r_state)
                S_START: begin
                    r_base[0] <= '0;
                    r_prev    <= '0;
                    r_k       <= NSW'(1);
                    r_acc     <= NUMW'(m);
                    r_num     <= NUMW'(m);
                    r_quo     <= '0;
                    r_rem     <= '0;
                    r_cnt     <= CNTW'(NUMW-1);
                    if (n == '0) begin
                        r_state <= S_IDLE;
                    end else if (n == NSW'(1)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[NUMW-2:0], ge};
                    r_num <= {r_num[NUMW-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_base[r_k[KW-1:0]]    <= bound;
                    r_cap[KW'(r_k - 1'b1)] <= span(r_prev, bound);
                    r_prev                 <= bound;
                    if (r_k == (n - 1'b1)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_acc   <= n_acc;
                        r_num   <= n_acc;
                        r_quo   <= '0;
                        r_rem   <= '0;
                        r_cnt   <= CNTW'(NUMW-1);
                        r_state <= S_DIV;
                    end
                end
                S_LAST: begin
                    // top region ends at the clamped memory size
                    r_cap[KW'(n - 1'b1)] <= span(r_prev, m);
                    r_state              <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == msm_pkg::REG_TOTAL_SIZE) begin
                            r_total_size <= i_cfg_data;
                            r_state      <= S_START;
                        end else if (i_cfg_index == msm_pkg::REG_STACK_COUNT) begin
                            r_stack_count <= i_cfg_data[msm_pkg::STACK_COUNT_W-1:0];
                            r_state       <= S_START;
                        end
                    end
                end
                default: begin
                    r_state <= S_START;
                end
            endcase
        end
    end

    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_ctl.busy   = (r_state != S_IDLE);
    assign o_ctl.clear  = (r_state == S_START);
    assign o_used_count = n;
    assign o_base       = r_base;
    assign o_cap        = r_cap;

endmodule

// ===== hw/rtl/msm_front.sv =====
// Front end of the multi-stack core: input handshake and index check.
// Uses msm_pkg; feeds classified items into msm_queue.
module msm_front #(
    parameter int MAX_STACKS = 8
) (
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  msm_pkg::t_in_item                 i_in_data,
    input  logic [$clog2(MAX_STACKS+1)-1:0]   i_used_count,
    input  msm_pkg::t_rebuild_ctl             i_ctl,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output msm_pkg::t_q_entry                 o_q_entry
);

    localparam int NSW = $clog2(MAX_STACKS+1);
    localparam int IW  = (NSW > msm_pkg::INDEX_W) ? NSW : msm_pkg::INDEX_W;

    // hold off input while bounds are rebuilt or the queue is full
    assign o_in_stall = i_ctl.busy || i_q_full;
    assign o_q_push   = i_in_valid && !o_in_stall;

    assign o_q_entry.cmd         = i_in_data.cmd;
    assign o_q_entry.bad_index   = (IW'(i_in_data.stack_index) >= IW'(i_used_count));
    assign o_q_entry.stack_index = i_in_data.stack_index;
    assign o_q_entry.value       = i_in_data.value;

endmodule

// ===== hw/rtl/msm_queue.sv =====
// Two-entry queue between front end and back end of the multi-stack core.
// Uses msm_pkg for the entry type.
module msm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  msm_pkg::t_q_entry  i_entry,
    output logic               o_full,
    output logic               o_valid,
    output msm_pkg::t_q_entry  o_entry,
    input  logic               i_pop
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH+1);

    msm_pkg::t_q_entry r_slot [DEPTH];
    logic [PW-1:0]     r_wr;
    logic [PW-1:0]     r_rd;
    logic [CW-1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_entry;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd];

endmodule

// ===== hw/rtl/msm_back.sv =====
// Back end of the multi-stack core: fill counts, element memory, result register.
// Uses msm_pkg; takes region bases and capacities from msm_bounds.
module msm_back #(
    parameter int MEM_DEPTH  = 1024,
    parameter int MAX_STACKS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  msm_pkg::t_q_entry                  i_q_entry,
    output logic                               o_q_pop,
    input  msm_pkg::t_rebuild_ctl              i_ctl,
    input  logic [$clog2(MEM_DEPTH+1)-1:0]     i_base [MAX_STACKS],
    input  logic [$clog2(MEM_DEPTH+1)-1:0]     i_cap  [MAX_STACKS],
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output msm_pkg::t_out_item                 o_out_data
);

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int SZW = $clog2(MEM_DEPTH+1);
    localparam int KW  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;

    logic [msm_pkg::VALUE_W-1:0] r_mem [MEM_DEPTH];
    logic [msm_pkg::VALUE_W-1:0] r_rdata;
    logic [SZW-1:0]              r_fill [MAX_STACKS];
    logic                        r_out_valid;
    logic                        r_pop_ok;
    msm_pkg::t_status            r_status;

    logic              fire;
    logic [KW-1:0]     k;
    logic [SZW-1:0]    fill;
    logic              is_push;
    logic              push_ok;
    logic              pop_ok;
    logic              do_wr;
    logic              do_rd;
    logic [SZW-1:0]    slot;
    logic [AW-1:0]     addr;
    msm_pkg::t_status  status;

    // advance when the result register is free or being drained
    assign fire    = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = fire;

    assign k       = KW'(i_q_entry.stack_index);
    assign fill    = r_fill[k];
    assign is_push = (i_q_entry.cmd == msm_pkg::CMD_PUSH);
    assign push_ok = (fill < i_cap[k]);
    assign pop_ok  = (fill != '0);
    assign do_wr   = fire && !i_q_entry.bad_index && is_push && push_ok;
    assign do_rd   = fire && !i_q_entry.bad_index && !is_push && pop_ok;
    assign slot    = i_base[k] + (is_push ? fill : (fill - 1'b1));
    assign addr    = slot[AW-1:0];

    always_comb begin
        priority if (i_q_entry.bad_index) begin
            status = msm_pkg::ST_BAD_INDEX;
        end else if (is_push) begin
            status = push_ok ? msm_pkg::ST_OK : msm_pkg::ST_OVERFLOW;
        end else begin
            status = pop_ok ? msm_pkg::ST_OK : msm_pkg::ST_UNDERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int i = 0; i < MAX_STACKS; i++) begin
                r_fill[i] <= '0;
            end
        end else if (do_wr) begin
            r_fill[k] <= fill + 1'b1;
        end else if (do_rd) begin
            r_fill[k] <= fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[addr] <= i_q_entry.value;
        end
        if (do_rd) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= status;
            r_pop_ok <= do_rd;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_data.popped_value = r_pop_ok ? signed'(r_rdata) : '0;
    assign o_out_data.status       = r_status;

endmodule

// ===== hw/rtl/multi_stack_shared_memory_core.sv =====
// Multi-stack core: up to MAX_STACKS stacks in fixed regions of one MEM_DEPTH-word memory.
// Top level; uses msm_pkg, msm_bounds, msm_front, msm_queue and msm_back.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries push or pop commands;
// a transfer happens at an edge with valid high and stall low. Each item yields exactly
// one result on the output channel (o_out_valid / i_out_stall / o_out_data): the popped
// word, or zero, with a status of ok, overflow, underflow or invalid stack index.
// An item passes through the queue and then the result register. Throughput: one item per
// cycle while no stall holds it, set by the single memory port and the fill-count update.
// When the receiver stalls, the result register holds its value; the two-entry queue
// behind it absorbs up to two more items, after which o_in_stall rises.
// Configuration (i_cfg_valid / o_cfg_ready, index 0 total_size, index 1 stack_count)
// is taken only while idle. Reset and every accepted write to a known register empty
// all stacks and recompute the region bounds with a bit-serial divider; while it runs
// o_cfg_ready is low and o_in_stall is high. Reset is synchronous and active low.
module multi_stack_shared_memory_core #(
    parameter int MEM_DEPTH  = 1024,
    parameter int MAX_STACKS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  msm_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output msm_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [msm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SZW = $clog2(MEM_DEPTH+1);
    localparam int NSW = $clog2(MAX_STACKS+1);

    logic [NSW-1:0]         used_count;
    msm_pkg::t_rebuild_ctl  ctl;
    logic [SZW-1:0]         base [MAX_STACKS];
    logic [SZW-1:0]         cap  [MAX_STACKS];
    logic                   q_push;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    msm_pkg::t_q_entry      q_in;
    msm_pkg::t_q_entry      q_head;

    msm_bounds #(
        .MEM_DEPTH  (MEM_DEPTH),
        .MAX_STACKS (MAX_STACKS)
    ) u_bounds (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_used_count (used_count),
        .o_ctl        (ctl),
        .o_base       (base),
        .o_cap        (cap)
    );

    msm_front #(
        .MAX_STACKS (MAX_STACKS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_used_count (used_count),
        .i_ctl        (ctl),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_entry    (q_in)
    );

    msm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_head),
        .i_pop   (q_pop)
    );

    msm_back #(
        .MEM_DEPTH  (MEM_DEPTH),
        .MAX_STACKS (MAX_STACKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_head),
        .o_q_pop     (q_pop),
        .i_ctl       (ctl),
        .i_base      (base),
        .i_cap       (cap),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/msm_checker.sv =====
// Port-level assertions of the multi-stack core and the bind that attaches them.
// Uses msm_pkg and multi_stack_shared_memory_core_macros.svh.
`include "multi_stack_shared_memory_core_macros.svh"

module msm_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input msm_pkg::t_out_item             o_out_data,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [msm_pkg::CFG_IDX_W-1:0]  i_cfg_index
);

    logic out_held;
    logic out_fail;
    logic cfg_write;

    assign out_held  = o_out_valid && i_out_stall;
    assign out_fail  = o_out_valid && (o_out_data.status != msm_pkg::ST_OK);
    assign cfg_write = i_cfg_valid && o_cfg_ready &&
                       ((i_cfg_index == msm_pkg::REG_TOTAL_SIZE) ||
                        (i_cfg_index == msm_pkg::REG_STACK_COUNT));

    // a stalled result stays put
    `MSM_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_out_data))

    // only a successful pop carries data
    `MSM_ASSERT_NOW(a_fail_zero, out_fail, o_out_data.popped_value == '0)

    // no input transfer while bounds are being rebuilt
    `MSM_ASSERT_NOW(a_busy_stall, !o_cfg_ready, o_in_stall)

    // a write to a known register starts a rebuild
    `MSM_ASSERT_NEXT(a_cfg_rebuild, cfg_write, !o_cfg_ready && o_in_stall)

endmodule

bind multi_stack_shared_memory_core msm_checker u_msm_checker (.*);
